@@ rtl/core/skvt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table package
// Shared sizes, operation and status codes, and the compare result type.
// ----------------------------------------------------------------------------
package skvt_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OP_W     = 2;
	localparam int KEY_W    = 32;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 4;

	localparam int S_FIELDS_W = OP_W + KEY_W + VAL_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_FIELDS_W = STATUS_W + POS_W + VAL_W;
	localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic signed [VAL_W-1:0] val_t;

	typedef struct packed {
		logic lt;
		logic eq;
	} cmp_res_t;

endpackage

@@ rtl/core/skvt_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table entry store
// Key and value memories with one write port and one registered read port.
// ----------------------------------------------------------------------------
module skvt_store (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [skvt_pkg::IDX_W-1:0] wr_addr,
	input  skvt_pkg::key_t            wr_key,
	input  skvt_pkg::val_t            wr_val,
	input  logic [skvt_pkg::IDX_W-1:0] rd_addr,
	output skvt_pkg::key_t            rd_key,
	output skvt_pkg::val_t            rd_val
);
	import skvt_pkg::*;

	key_t key_mem [CAPACITY];
	val_t val_mem [CAPACITY];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_addr] <= wr_key;
			val_mem[wr_addr] <= wr_val;
		end
	end

	always_ff @(posedge clk) begin
		rd_key <= key_mem[rd_addr];
		rd_val <= val_mem[rd_addr];
	end

endmodule

@@ rtl/core/skvt_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table key comparator
// The single signed compare used by the scan steps of the sequencer.
// ----------------------------------------------------------------------------
module skvt_cmp (
	input  skvt_pkg::key_t     stored_key,
	input  skvt_pkg::key_t     probe_key,
	output skvt_pkg::cmp_res_t res
);
	import skvt_pkg::*;

	// Both operands are signed, so the less-than is a signed compare.
	assign res.lt = (stored_key < probe_key);
	assign res.eq = (stored_key == probe_key);

endmodule

@@ rtl/core/sorted_key_value_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted key/value table
// Bounded dictionary of signed keys and values kept in ascending key order.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel: op selects insert, delete or search,
// key is the signed key and item_value is stored on insert. Every request
// produces exactly one transfer on the m_axis channel with a status, the
// sorted position (insert and search) and the stored value (search hit).
// The block handles one request at a time. After the request transfer the
// single comparator walks the stored entries from index zero, one entry per
// cycle, until it reaches the first key that is not below the request key
// or the end of the stored entries. An insert then moves the later entries up
// one slot and a delete moves them down, one entry per cycle through the
// single memory write port. Together the scan and the shift cover the table
// about once. The sequencer then moves the result into the output register
// and returns to idle for the next request. s_axis_tready is high only while
// the sequencer is idle. The result sits in an output register, so a new
// request is taken while an earlier result still waits; if the receiver
// stalls, the next result waits in the sequencer until the register is free.
// Reset empties the table at once: the entry count goes to zero and the
// memories themselves are not cleared.
// ----------------------------------------------------------------------------
module sorted_key_value_table (
	input  logic                           clk,
	input  logic                           arst_n,
	// tdata fields from bit 0 up: op[1:0], key[33:2], item_value[65:34], zero pad
	input  logic [skvt_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// tdata fields from bit 0 up: status[1:0], position[5:2], found_value[37:6], zero pad
	output logic [skvt_pkg::M_TDATA_W-1:0] m_axis_tdata,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready
);
	import skvt_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_SHUP   = 3'd2;
	localparam logic [2:0] S_SHDN   = 3'd3;
	localparam logic [2:0] S_RESULT = 3'd4;

	logic [2:0]          state_q;
	logic [OP_W-1:0]     op_q;
	key_t                key_q;
	val_t                val_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    idx_q;
	logic [CNT_W-1:0]    j_q;
	logic [STATUS_W-1:0] res_status_q;
	logic [POS_W-1:0]    res_pos_q;
	val_t                res_fv_q;
	logic [M_TDATA_W-1:0] out_data_q;
	logic                out_valid_q;

	logic                in_xfer;
	logic                out_free;
	logic                in_range;
	logic                scan_go;
	logic                present;
	logic                wr_en;
	logic [IDX_W-1:0]    wr_addr;
	key_t                wr_key;
	val_t                wr_val;
	logic [IDX_W-1:0]    rd_addr;
	key_t                rd_key;
	val_t                rd_val;
	cmp_res_t            cmp_res;

	skvt_store u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_key  (wr_key),
		.wr_val  (wr_val),
		.rd_addr (rd_addr),
		.rd_key  (rd_key),
		.rd_val  (rd_val)
	);

	skvt_cmp u_cmp (
		.stored_key (rd_key),
		.probe_key  (key_q),
		.res        (cmp_res)
	);

	assign s_axis_tready = (state_q == S_IDLE);
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tvalid = out_valid_q;

	// During the scan the read data belongs to entry idx_q.
	assign in_range = (idx_q < cnt_q);
	assign scan_go  = in_range && cmp_res.lt;
	assign present  = in_range && cmp_res.eq;

	// Read address: the read issued now returns data for the next cycle.
	always_comb begin
		rd_addr = '0;
		unique case (state_q)
			S_SCAN: begin
				if (scan_go || (op_q != OP_INSERT)) begin
					rd_addr = IDX_W'(idx_q + CNT_W'(1));
				end else begin
					rd_addr = IDX_W'(cnt_q - CNT_W'(1));
				end
			end
			S_SHUP:  rd_addr = IDX_W'(j_q - CNT_W'(2));
			S_SHDN:  rd_addr = IDX_W'(j_q + CNT_W'(2));
			default: rd_addr = '0;
		endcase
	end

	// Write port: shifting copies the entry just read, the insert ends with
	// the new key at its sorted place.
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = IDX_W'(j_q);
		wr_key  = rd_key;
		wr_val  = rd_val;
		unique case (state_q)
			S_SHUP: begin
				wr_en = 1'b1;
				if (j_q == idx_q) begin
					wr_key = key_q;
					wr_val = val_q;
				end
			end
			S_SHDN:  wr_en = ((j_q + CNT_W'(1)) < cnt_q);
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// The register fills from the sequencer or holds until its transfer.
			out_valid_q <= ((state_q == S_RESULT) && out_free) ||
				(out_valid_q && !m_axis_tready);
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (!scan_go) begin
						if ((op_q == OP_INSERT) && !present && (cnt_q != CNT_W'(CAPACITY))) begin
							state_q <= S_SHUP;
						end else if ((op_q == OP_DELETE) && present) begin
							state_q <= S_SHDN;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_SHUP: begin
					if (j_q == idx_q) begin
						cnt_q   <= cnt_q + CNT_W'(1);
						state_q <= S_RESULT;
					end
				end
				S_SHDN: begin
					if (!((j_q + CNT_W'(1)) < cnt_q)) begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_RESULT;
					end
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Request fields, scan pointer, shift pointer and result payload.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					op_q  <= s_axis_tdata[OP_W-1:0];
					key_q <= s_axis_tdata[OP_W +: KEY_W];
					val_q <= s_axis_tdata[OP_W + KEY_W +: VAL_W];
					idx_q <= '0;
				end
			end
			S_SCAN: begin
				if (scan_go) begin
					idx_q <= idx_q + CNT_W'(1);
				end else begin
					unique case (op_q)
						OP_INSERT: begin
							res_fv_q <= '0;
							if (present) begin
								res_status_q <= ST_DUP;
								res_pos_q    <= POS_W'(idx_q);
							end else if (cnt_q == CNT_W'(CAPACITY)) begin
								res_status_q <= ST_FULL;
								res_pos_q    <= '0;
							end else begin
								res_status_q <= ST_DONE;
								res_pos_q    <= POS_W'(idx_q);
								j_q          <= cnt_q;
							end
						end
						OP_DELETE: begin
							res_pos_q <= '0;
							res_fv_q  <= '0;
							if (present) begin
								res_status_q <= ST_DONE;
								j_q          <= idx_q;
							end else begin
								res_status_q <= ST_MISSING;
							end
						end
						OP_SEARCH: begin
							if (present) begin
								res_status_q <= ST_DONE;
								res_pos_q    <= POS_W'(idx_q);
								res_fv_q     <= rd_val;
							end else begin
								res_status_q <= ST_MISSING;
								res_pos_q    <= '0;
								res_fv_q     <= '0;
							end
						end
						default: begin
							res_status_q <= ST_DONE;
							res_pos_q    <= '0;
							res_fv_q     <= '0;
						end
					endcase
				end
			end
			S_SHUP: begin
				if (j_q != idx_q) begin
					j_q <= j_q - CNT_W'(1);
				end
			end
			S_SHDN: begin
				j_q <= j_q + CNT_W'(1);
			end
			S_RESULT: begin
				if (out_free) begin
					out_data_q <= M_TDATA_W'({res_fv_q, res_pos_q, res_status_q});
				end
			end
			default: j_q <= j_q;
		endcase
	end

endmodule
